/* rtl/n2a_pkg.sv */
// Shared constants, types and helper functions of the number-to-ASCII formatter.
package n2a_pkg;

   // Input width that the decimal path converts, capped at the 32-bit value port.
   localparam int VALUE_BITS = 32;
   localparam int DEC_BITS   = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   // Decimal digits needed for DEC_BITS bits: floor(DEC_BITS * log10(2)) + 1.
   localparam int DEC_DIGITS = ((DEC_BITS * 1233) >> 12) + 1;
   localparam int BCD_BITS   = 4 * DEC_DIGITS;
   localparam int BIT_CNT_W  = $clog2(DEC_BITS + 1);

   // Hex digit count, held to the range 1 to 8.
   localparam int HEX_DIGITS = 4;
   localparam int HEX_COUNT  = (HEX_DIGITS > 8) ? 8 : ((HEX_DIGITS < 1) ? 1 : HEX_DIGITS);
   localparam int HEX_BITS   = 4 * HEX_COUNT;

   // One down-counter serves both digit runs.
   localparam int RUN_MAX    = (DEC_DIGITS > HEX_COUNT) ? DEC_DIGITS : HEX_COUNT;
   localparam int RUN_CNT_W  = $clog2(RUN_MAX + 1);

   // Operation codes.
   localparam logic [1:0] OP_CHAR = 2'd0;
   localparam logic [1:0] OP_DEC  = 2'd1;
   localparam logic [1:0] OP_HEX  = 2'd2;

   // ASCII characters.
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_A    = 8'h61;
   localparam logic [7:0] CHAR_X    = 8'h78;
   localparam logic [7:0] DEC_RADIX = 8'd10;

   // Commands from the sequencer to the decimal converter.
   typedef struct packed {
      logic load;
      logic shift;
   } bcd_ctl_type;

   // Lower-case hex character of one nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      if (wide < DEC_RADIX) begin
         hex_char = CHAR_ZERO + wide;
      end else begin
         hex_char = CHAR_A + wide - DEC_RADIX;
      end
   endfunction

endpackage

/* rtl/n2a_bcd.sv */
// Bit-serial binary to BCD converter (shift and add 3) with a digit shift-out port.
module n2a_bcd (
   input  logic                         clock,
   input  logic                         reset,
   input  n2a_pkg::bcd_ctl_type         ctl,
   input  logic [n2a_pkg::DEC_BITS-1:0] load_value,
   output logic                         running,
   output logic [3:0]                   top_digit
);

   logic [n2a_pkg::DEC_BITS-1:0]  bin_ff, bin_in;
   logic [n2a_pkg::BCD_BITS-1:0]  bcd_ff, bcd_in;
   logic [n2a_pkg::BCD_BITS-1:0]  bcd_adj;
   logic [n2a_pkg::BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          run_ff, run_in;

   // Each digit lane adds 3 when it holds 5 or more, ahead of the shift.
   always_comb begin
      for (int i = 0; i < n2a_pkg::DEC_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // Load, one conversion step per cycle, or a digit shift toward the top.
   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (ctl.load) begin
         bin_in = load_value;
         bcd_in = '0;
         cnt_in = n2a_pkg::BIT_CNT_W'(n2a_pkg::DEC_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         bin_in = {bin_ff[n2a_pkg::DEC_BITS-2:0], 1'b0};
         bcd_in = {bcd_adj[n2a_pkg::BCD_BITS-2:0], bin_ff[n2a_pkg::DEC_BITS-1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == n2a_pkg::BIT_CNT_W'(1)) begin
            run_in = 1'b0;
         end
      end else if (ctl.shift) begin
         bcd_in = {bcd_ff[n2a_pkg::BCD_BITS-5:0], 4'h0};
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   // Data shift registers.
   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign running   = run_ff;
   assign top_digit = bcd_ff[n2a_pkg::BCD_BITS-1 -: 4];

endmodule

/* rtl/number_to_ascii_formatter.sv */
// Top level of the number-to-ASCII formatter: operation sequencer and result register.
//
//  Channel   Ports                                  Transfer
//  request   start, busy, req_operation, req_value  start high while busy low
//  response  rsp_strobe, rsp_text_byte, rsp_last    every cycle rsp_strobe is high
//
// A character yields one result, or a CR and then the character for a line feed; a hex
// item yields '0', 'x' and HEX_COUNT digits. A decimal item runs the bit-serial converter
// for one step per input bit (32), then shifts the BCD register one digit at a time
// through leading zeros and the printed digits. The converter is the part that sets the decimal time.
// Reset is synchronous and returns the block to idle with no result pending.
// Once a run's characters start they come one per cycle, and the receiver cannot stall them.
module number_to_ascii_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_value,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_text_byte,
   output logic        rsp_last
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_CR       = 3'd1;
   localparam logic [2:0] S_CHAR     = 3'd2;
   localparam logic [2:0] S_CONVERT  = 3'd3;
   localparam logic [2:0] S_DEC_SKIP = 3'd4;
   localparam logic [2:0] S_DEC_EMIT = 3'd5;
   localparam logic [2:0] S_HEX_X    = 3'd6;
   localparam logic [2:0] S_HEX_DIG  = 3'd7;

   logic [2:0]                    state_ff, state_in;
   logic [n2a_pkg::RUN_CNT_W-1:0] count_ff, count_in;
   logic [7:0]                    char_ff, char_in;
   logic [n2a_pkg::HEX_BITS-1:0]  hex_ff, hex_in;
   logic                          strobe_ff, strobe_in;
   logic [7:0]                    byte_ff, byte_in;
   logic                          last_ff, last_in;
   logic                          accept;
   n2a_pkg::bcd_ctl_type          bcd_ctl;
   logic                          bcd_running;
   logic [3:0]                    bcd_top;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   n2a_bcd u_bcd (
      .clock      (clock),
      .reset      (reset),
      .ctl        (bcd_ctl),
      .load_value (req_value[n2a_pkg::DEC_BITS-1:0]),
      .running    (bcd_running),
      .top_digit  (bcd_top)
   );

   // Sequencer: picks the next character and when the run ends.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      char_in       = char_ff;
      hex_in        = hex_ff;
      strobe_in     = 1'b0;
      byte_in       = byte_ff;
      last_in       = 1'b0;
      bcd_ctl.load  = 1'b0;
      bcd_ctl.shift = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_operation)
                  n2a_pkg::OP_CHAR: begin
                     char_in = req_value[7:0];
                     if (req_value[7:0] == n2a_pkg::CHAR_LF) begin
                        state_in = S_CR;
                     end else begin
                        state_in = S_CHAR;
                     end
                  end
                  n2a_pkg::OP_DEC: begin
                     bcd_ctl.load = 1'b1;
                     count_in     = n2a_pkg::RUN_CNT_W'(n2a_pkg::DEC_DIGITS);
                     state_in     = S_CONVERT;
                  end
                  n2a_pkg::OP_HEX: begin
                     // The leading '0' goes out right away.
                     hex_in    = req_value[n2a_pkg::HEX_BITS-1:0];
                     count_in  = n2a_pkg::RUN_CNT_W'(n2a_pkg::HEX_COUNT);
                     strobe_in = 1'b1;
                     byte_in   = n2a_pkg::CHAR_ZERO;
                     state_in  = S_HEX_X;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CR: begin
            strobe_in = 1'b1;
            byte_in   = n2a_pkg::CHAR_CR;
            state_in  = S_CHAR;
         end
         S_CHAR: begin
            strobe_in = 1'b1;
            byte_in   = char_ff;
            last_in   = 1'b1;
            state_in  = S_IDLE;
         end
         S_CONVERT: begin
            if (!bcd_running) begin
               state_in = S_DEC_SKIP;
            end
         end
         S_DEC_SKIP: begin
            // Drop leading zeros, but always keep the units digit.
            if (bcd_top == 4'h0 && count_ff != n2a_pkg::RUN_CNT_W'(1)) begin
               bcd_ctl.shift = 1'b1;
               count_in      = count_ff - 1'b1;
            end else begin
               state_in = S_DEC_EMIT;
            end
         end
         S_DEC_EMIT: begin
            strobe_in     = 1'b1;
            byte_in       = n2a_pkg::CHAR_ZERO + {4'h0, bcd_top};
            bcd_ctl.shift = 1'b1;
            count_in      = count_ff - 1'b1;
            if (count_ff == n2a_pkg::RUN_CNT_W'(1)) begin
               last_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_HEX_X: begin
            strobe_in = 1'b1;
            byte_in   = n2a_pkg::CHAR_X;
            state_in  = S_HEX_DIG;
         end
         S_HEX_DIG: begin
            strobe_in = 1'b1;
            byte_in   = n2a_pkg::hex_char(hex_ff[n2a_pkg::HEX_BITS-1 -: 4]);
            hex_in    = hex_ff << 4;
            count_in  = count_ff - 1'b1;
            if (count_ff == n2a_pkg::RUN_CNT_W'(1)) begin
               last_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and the result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      char_ff <= char_in;
      hex_ff  <= hex_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_text_byte = byte_ff;
   assign rsp_last      = last_ff;

endmodule

/* sim/n2a_checker.sv */
// Checker for the number-to-ASCII formatter: predicts each character run and compares it.
`timescale 1ns / 1ps

module n2a_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_value,
   input  logic        rsp_strobe,
   input  logic [7:0]  rsp_text_byte,
   input  logic        rsp_last,
   output int          error_count,
   output int          pending_count
);

   // One character of formatted text as it should appear on the result ports.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       last;
   } text_char_type;

   text_char_type expected_text[$];
   int            mismatches = 0;
   int            pending    = 0;

   assign error_count   = mismatches;
   assign pending_count = pending;

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
   endtask

   function automatic void push_char(input logic [7:0] ch, input logic is_last);
      text_char_type entry;
      entry.text_byte = ch;
      entry.last      = is_last;
      expected_text.push_back(entry);
   endfunction

   // Appends the character run that one request is expected to produce.
   function automatic void queue_text(input logic [1:0] operation, input logic [31:0] value);
      logic [3:0]  dec_digit [n2a_pkg::DEC_DIGITS];
      logic [31:0] dec_mask;
      logic [31:0] rest;
      logic [3:0]  nib;
      int          count;
      case (operation)
         n2a_pkg::OP_CHAR: begin
            // A line feed goes out as carriage return plus line feed.
            if (value[7:0] == n2a_pkg::CHAR_LF) begin
               push_char(n2a_pkg::CHAR_CR, 1'b0);
            end
            push_char(value[7:0], 1'b1);
         end
         n2a_pkg::OP_DEC: begin
            // Collect digits least significant first; zero still yields one digit.
            dec_mask = 32'((64'd1 << n2a_pkg::DEC_BITS) - 64'd1);
            rest     = value & dec_mask;
            count    = 0;
            do begin
               dec_digit[count] = 4'(rest % n2a_pkg::DEC_RADIX);
               rest             = rest / n2a_pkg::DEC_RADIX;
               count++;
            end while (rest != 0);
            for (int i = count - 1; i >= 0; i--) begin
               push_char(n2a_pkg::CHAR_ZERO + {4'h0, dec_digit[i]}, i == 0);
            end
         end
         n2a_pkg::OP_HEX: begin
            push_char(n2a_pkg::CHAR_ZERO, 1'b0);
            push_char(n2a_pkg::CHAR_X, 1'b0);
            for (int k = n2a_pkg::HEX_COUNT - 1; k >= 0; k--) begin
               nib = 4'(value >> (4 * k));
               if ({4'h0, nib} < n2a_pkg::DEC_RADIX) begin
                  push_char(n2a_pkg::CHAR_ZERO + {4'h0, nib}, k == 0);
               end else begin
                  push_char(n2a_pkg::CHAR_A + {4'h0, nib} - n2a_pkg::DEC_RADIX, k == 0);
               end
            end
         end
         default: begin
            // The unused operation code produces no text.
         end
      endcase
   endfunction

   // Results are compared before new requests are queued, since a result never
   // belongs to a request accepted at the same edge.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("unexpected result byte 0x%02h last %0b",
                                         rsp_text_byte, rsp_last));
            end else begin
               want = expected_text.pop_front();
               if (rsp_text_byte !== want.text_byte) begin
                  report_mismatch($sformatf("text_byte 0x%02h, expected 0x%02h",
                                            rsp_text_byte, want.text_byte));
               end
               if (rsp_last !== want.last) begin
                  report_mismatch($sformatf("last %0b, expected %0b on byte 0x%02h",
                                            rsp_last, want.last, want.text_byte));
               end
            end
         end
         if (start && !busy) begin
            queue_text(req_operation, req_value);
         end
      end
      pending = expected_text.size();
   end

endmodule

/* sim/tb.sv */
// Testbench top for the number-to-ASCII formatter: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb;

   // Operation code that the block accepts and ignores.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_PER_PHASE  = 104;
   localparam int DRAIN_CYCLES      = 60;
   localparam int CYCLE_LIMIT       = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_operation = n2a_pkg::OP_CHAR;
   logic [31:0] req_value = '0;
   logic        rsp_strobe;
   logic [7:0]  rsp_text_byte;
   logic        rsp_last;
   int          error_count;
   int          pending_count;
   int          cycle_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   number_to_ascii_formatter u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_text_byte (rsp_text_byte),
      .rsp_last      (rsp_last)
   );

   n2a_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_text_byte (rsp_text_byte),
      .rsp_last      (rsp_last),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Guards against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Drives one request at the falling edge and holds it until the block takes it.
   task automatic send_request(input logic [1:0] operation, input logic [31:0] value);
      @(negedge clock);
      start         = 1'b1;
      req_operation = operation;
      req_value     = value;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // Drops start for a random stretch with the given chance in a hundred.
   task automatic maybe_idle(input int percent);
      int gap;
      if ($urandom_range(99, 0) < percent) begin
         gap = $urandom_range(8, 1);
         repeat (gap) begin
            @(negedge clock);
            start = 1'b0;
         end
      end
   endtask

   // Random request mix: mostly real operations, with some unused codes and
   // a good share of line feeds and short decimal numbers.
   task automatic send_random(input int idle_percent);
      int          pick;
      logic [31:0] value;
      maybe_idle(idle_percent);
      pick  = $urandom_range(19, 0);
      value = $urandom;
      if (pick < 6) begin
         if ($urandom_range(5, 0) == 0) begin
            value[7:0] = n2a_pkg::CHAR_LF;
         end
         send_request(n2a_pkg::OP_CHAR, value);
      end else if (pick < 13) begin
         send_request(n2a_pkg::OP_DEC, value >> $urandom_range(31, 0));
      end else if (pick < 19) begin
         send_request(n2a_pkg::OP_HEX, value);
      end else begin
         send_request(OP_UNUSED, value);
      end
   endtask

   initial begin
      // Hold reset, then release it at a falling edge.
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes, each operation and the special cases.
      send_request(n2a_pkg::OP_CHAR, 32'h0000_0000);
      send_request(n2a_pkg::OP_CHAR, 32'h0000_00FF);
      send_request(n2a_pkg::OP_CHAR, 32'h0000_000A);
      send_request(n2a_pkg::OP_CHAR, 32'hFFFF_FF0A);
      send_request(n2a_pkg::OP_CHAR, 32'hA5A5_5A41);
      send_request(n2a_pkg::OP_CHAR, 32'h0000_000D);
      send_request(n2a_pkg::OP_DEC, 32'd0);
      send_request(n2a_pkg::OP_DEC, 32'd1);
      send_request(n2a_pkg::OP_DEC, 32'd9);
      send_request(n2a_pkg::OP_DEC, 32'd10);
      send_request(n2a_pkg::OP_DEC, 32'd1000000000);
      send_request(n2a_pkg::OP_DEC, 32'hFFFF_FFFF);
      send_request(n2a_pkg::OP_HEX, 32'h0000_0000);
      send_request(n2a_pkg::OP_HEX, 32'h0000_FFFF);
      send_request(n2a_pkg::OP_HEX, 32'h1234_ABCD);
      send_request(n2a_pkg::OP_HEX, 32'hFFFF_A5F0);
      send_request(OP_UNUSED, 32'h0000_0000);
      send_request(n2a_pkg::OP_CHAR, 32'h0000_0030);
      send_request(OP_UNUSED, 32'hFFFF_FFFF);
      send_request(n2a_pkg::OP_DEC, 32'd42);

      // Random phases: light sender gaps, heavy sender gaps, then back to back.
      repeat (RANDOM_PER_PHASE) send_random(12);
      repeat (RANDOM_PER_PHASE) send_random(60);
      repeat (RANDOM_PER_PHASE) send_random(0);

      @(negedge clock);
      start = 1'b0;

      // Let the last runs drain, then allow time for anything stray.
      while (pending_count != 0 || busy) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
